// ===== src/sorted_list_insert_find_remove_assert.svh =====
// Assertion macros for the sorted list block.
// Used by the top level only; needs no package.
`ifndef SORTED_LIST_INSERT_FIND_REMOVE_ASSERT_SVH
`define SORTED_LIST_INSERT_FIND_REMOVE_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define SLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/slt_pkg.sv =====
// Shared types and codes for the sorted list block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package slt_pkg;

    // Fixed widths of the transfer fields
    localparam int OP_W  = 2;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int POS_W = 4;
    localparam int CNT_W = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
    localparam logic [ST_W-1:0] ST_MISSING = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] count;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic compare;
        logic execute;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_valid;
    } t_sts;

endpackage

// ===== src/slt_ctrl.sv =====
// Controller for the sorted list block: capture, compare and execute sequencing.
// Depends on slt_pkg for the command and status structs.
`timescale 1ns / 1ps

module slt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_out_stall,
    input  slt_pkg::t_sts i_sts,
    output slt_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_WAIT = 3'b001,
        S_CMP  = 3'b010,
        S_EXE  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   out_free;
    logic   in_ready;
    logic   accept;

    // Result slot frees when empty or being taken this cycle
    assign out_free = !i_sts.out_valid || !i_out_stall;
    assign in_ready = i_rst_n &&
                      ((r_state == S_WAIT) || ((r_state == S_EXE) && out_free));
    assign accept   = i_in_valid && in_ready;

    assign o_in_stall      = !in_ready;
    assign o_cmd.capture   = accept;
    assign o_cmd.compare   = (r_state == S_CMP);
    assign o_cmd.execute   = (r_state == S_EXE) && out_free;

    // Advance the sequence
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_WAIT: begin
                if (accept) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_EXE;
            end
            S_EXE: begin
                if (out_free) n_state = accept ? S_CMP : S_WAIT;
            end
            default: begin
                n_state = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WAIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/slt_dp.sv =====
// Datapath for the sorted list block: entry cells, compare vectors, result register.
// Depends on slt_pkg for transfer types, codes and command/status structs.
`timescale 1ns / 1ps

module slt_dp #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  slt_pkg::t_cmd      i_cmd,
    output slt_pkg::t_sts      o_sts,
    input  slt_pkg::t_in_item  i_in_data,
    input  logic               i_out_stall,
    output slt_pkg::t_out_item o_out_data
);

    localparam int HW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic [slt_pkg::OP_W-1:0]         r_op;
    logic signed [slt_pkg::VAL_W-1:0] r_value;
    logic signed [slt_pkg::VAL_W-1:0] r_entries [CAPACITY];
    logic signed [slt_pkg::VAL_W-1:0] n_entries [CAPACITY];
    logic [HW-1:0]                    r_held;
    logic [HW-1:0]                    n_held;
    logic [CAPACITY-1:0]              le_vec;
    logic [CAPACITY-1:0]              seen_vec;
    logic [CAPACITY-1:0]              r_le;
    logic [CAPACITY-1:0]              r_seen;
    logic                             full;
    logic                             found;
    logic                             ins_go;
    logic                             rem_go;
    logic [IW-1:0]                    ins_pos;
    logic [IW-1:0]                    hit_pos;
    slt_pkg::t_out_item               r_out;
    slt_pkg::t_out_item               n_out;
    logic                             r_out_valid;

    // Hold the operation while it is worked on
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_in_data.op;
            r_value <= i_in_data.value;
        end
    end

    // Compare every held cell with the operand
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cmp
        logic held_cell;
        logic eq;
        assign held_cell = (HW'(g) < r_held);
        assign le_vec[g] = held_cell && (r_entries[g] <= r_value);
        assign eq        = held_cell && (r_entries[g] == r_value);
        if (g == 0) begin : g_first
            assign seen_vec[g] = eq;
        end else begin : g_rest
            assign seen_vec[g] = seen_vec[g-1] | eq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            r_le   <= le_vec;
            r_seen <= seen_vec;
        end
    end

    // Decide the update from the registered compare vectors
    assign full    = (r_held == HW'(CAPACITY));
    assign found   = r_seen[CAPACITY-1];
    assign ins_go  = (r_op == slt_pkg::OP_INSERT) && !full;
    assign rem_go  = (r_op == slt_pkg::OP_REMOVE) && found;
    assign ins_pos = IW'($countones(r_le));
    assign hit_pos = IW'($countones(~r_seen));

    // Shift cells up on insert, down on remove
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [slt_pkg::VAL_W-1:0] from_below;
        logic signed [slt_pkg::VAL_W-1:0] from_above;
        if (g == 0) begin : g_lo
            assign from_below = r_value;
        end else begin : g_hi
            assign from_below = r_le[g-1] ? r_value : r_entries[g-1];
        end
        if (g == CAPACITY - 1) begin : g_top
            assign from_above = r_entries[g];
        end else begin : g_mid
            assign from_above = r_entries[g+1];
        end
        always_comb begin
            n_entries[g] = r_entries[g];
            if (ins_go && !r_le[g]) begin
                n_entries[g] = from_below;
            end else if (rem_go && r_seen[g]) begin
                n_entries[g] = from_above;
            end
        end
    end

    always_comb begin
        n_held = r_held;
        if (ins_go) begin
            n_held = r_held + HW'(1);
        end else if (rem_go) begin
            n_held = r_held - HW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_entries[i] <= n_entries[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_cmd.execute) begin
            r_held <= n_held;
        end
    end

    // Build the result
    always_comb begin
        n_out.status   = slt_pkg::ST_OK;
        n_out.position = '0;
        n_out.count    = slt_pkg::CNT_W'(n_held);
        case (r_op)
            slt_pkg::OP_INSERT: begin
                if (full) begin
                    n_out.status = slt_pkg::ST_FULL;
                end else begin
                    n_out.position = slt_pkg::POS_W'(ins_pos);
                end
            end
            slt_pkg::OP_FIND, slt_pkg::OP_REMOVE: begin
                if (found) begin
                    n_out.position = slt_pkg::POS_W'(hit_pos);
                end else begin
                    n_out.status = slt_pkg::ST_MISSING;
                end
            end
            default: begin
                n_out.status = slt_pkg::ST_OK;
            end
        endcase
    end

    // Result register; drop valid once the transfer completes
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.execute) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_valid = r_out_valid;
    assign o_out_data      = r_out;

endmodule

// ===== src/sorted_list_insert_find_remove.sv =====
// Sorted list block: keeps up to CAPACITY signed values in ascending order.
// Input channel: i_in_valid / o_in_stall with i_in_data (op, value).
// Output channel: o_out_valid / i_out_stall with o_out_data (status, position, count).
// Ops: insert (after all equal entries), find (first match), remove (first match).
// Every accepted operation gives exactly one result transfer.
// The input transfer registers the operand; the compare step then checks it
// against every held cell in parallel and registers the compare vectors;
// the execute step shifts the cells and loads the result register.
// The compare/execute pair of the controller sets the pace: the next input
// is taken in the execute step, once the result slot is free.
// A full list rejects an insert with status full; a missing value gives
// status not found; both leave the list unchanged. Op code 3 changes nothing.
// Reset (synchronous, active low) empties the list and clears the result valid;
// no input is taken while reset is held.
// When the receiver stalls, the result holds in its register and the block
// stops in the execute step, stalling the input until the slot frees.
// Depends on slt_pkg, slt_ctrl, slt_dp and the assertion macro header.
`timescale 1ns / 1ps

module sorted_list_insert_find_remove #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  slt_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output slt_pkg::t_out_item o_out_data
);

    slt_pkg::t_cmd cmd;
    slt_pkg::t_sts sts;

    slt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    slt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    assign o_out_valid = sts.out_valid;

    // Checks
    `include "sorted_list_insert_find_remove_assert.svh"

    `SLT_ASSERT_NEXT(a_no_back_to_back, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken in two consecutive cycles")
    `SLT_ASSERT_NOW(a_fail_pos_zero, i_clk, i_rst_n, o_out_valid && (o_out_data.status != slt_pkg::ST_OK), o_out_data.position == '0, "failed operation reports a non-zero position")
    `SLT_ASSERT_NOW(a_full_count, i_clk, i_rst_n, o_out_valid && (o_out_data.status == slt_pkg::ST_FULL), o_out_data.count == slt_pkg::CNT_W'(CAPACITY), "full rejection with list not full")

endmodule
